### hw/rtl/kmst_pkg.sv
// ----------------------------------------------------------------------------
// kmst_pkg
// Types and constants shared by the minimum spanning tree block.
// ----------------------------------------------------------------------------
package kmst_pkg;

    localparam int MAX_NODES   = 64;
    localparam int MAX_EDGES   = 256;
    localparam int WEIGHT_BITS = 16;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int EDGE_BITS   = $clog2(MAX_EDGES);
    localparam int COUNT_BITS  = EDGE_BITS + 1;
    localparam int CFG_BITS    = 7;
    localparam int KEY_BITS    = WEIGHT_BITS + EDGE_BITS;
    localparam int OUT_CAP     = MAX_NODES - 1;
    localparam int OUT_CNT_BITS = $clog2(MAX_NODES);

    typedef struct packed {
        logic [NODE_BITS-1:0]          edge_from;
        logic [NODE_BITS-1:0]          edge_to;
        logic signed [WEIGHT_BITS-1:0] edge_weight;
        logic                          final_edge;
    } edge_word_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]          tree_from;
        logic [NODE_BITS-1:0]          tree_to;
        logic signed [WEIGHT_BITS-1:0] tree_weight;
        logic                          tree_last;
        logic                          tree_empty;
        logic                          dropped_flag;
    } tree_word_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]   from;
        logic [NODE_BITS-1:0]   to;
        logic [WEIGHT_BITS-1:0] weight;
    } stored_edge_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FA_RD,
        S_FA_CHK,
        S_FB_RD,
        S_FB_CHK,
        S_PUSH,
        S_FINISH
    } kmst_state_t;

endpackage

### hw/rtl/minimum_spanning_tree_kruskal.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal
// Kruskal spanning tree: edge store, selection walk by (weight, arrival),
// union-find parent store in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             word
//  edge      in         edge_valid/edge_stall edge_word (edge_word_t)
//  tree      out        tree_valid/tree_stall tree_word (tree_word_t)
//  config    in         cfg_we                cfg_wdata (node_count)
//
//  Edges load one per cycle into the edge memory. After the final edge, each
//  walk step scans all n stored edges for the next (weight, arrival) key,
//  follows the parent chains of its two end nodes to their roots, links the
//  roots if they differ and queues the edge while fewer than MAX_NODES - 1
//  are queued; a scan that finds no key ends the walk. The edge port stalls
//  for the whole walk. Reset marks every node a root at once; no clearing
//  pass. A full output register holds the walk.
module minimum_spanning_tree_kruskal
    import kmst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                edge_valid,
    output logic                edge_stall,
    input  edge_word_t          edge_word,
    output logic                tree_valid,
    input  logic                tree_stall,
    output tree_word_t          tree_word,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata
);

    // memories
    stored_edge_t         edge_mem [MAX_EDGES];
    logic [NODE_BITS-1:0] parent_mem [MAX_NODES];

    kmst_state_t state_reg, state_next;

    logic [CFG_BITS-1:0]   node_count_reg;
    logic [COUNT_BITS-1:0] edge_count_reg, edge_count_next;
    logic                  dropped_reg, dropped_next;
    logic                  run_drop_reg, run_drop_next;
    logic [MAX_NODES-1:0]  pvld_reg, pvld_next;

    // scan
    logic [COUNT_BITS-1:0] issue_reg, issue_next;
    logic                  rv_reg;
    logic [EDGE_BITS-1:0]  ridx_reg;
    stored_edge_t          rdata_reg;
    logic [KEY_BITS-1:0]   best_key_reg, best_key_next;
    logic                  best_vld_reg, best_vld_next;
    stored_edge_t          best_reg, best_next;
    logic [KEY_BITS-1:0]   prev_key_reg, prev_key_next;
    logic                  prev_vld_reg, prev_vld_next;

    // union-find
    logic [NODE_BITS-1:0]  cur_reg, cur_next;
    logic [NODE_BITS-1:0]  root_a_reg, root_a_next;
    logic [NODE_BITS-1:0]  pdata_reg;
    logic                  pdvld_reg;
    logic [NODE_BITS-1:0]  parent_of;

    // result queue
    tree_word_t            pend_reg, pend_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [OUT_CNT_BITS-1:0] pend_cnt_reg, pend_cnt_next;
    tree_word_t            out_reg, out_next;
    logic                  out_vld_reg, out_vld_next;

    logic                  in_take, edge_ok, out_free, rd_issue, link_en;
    logic [KEY_BITS-1:0]   cand_key;
    logic                  cand_better;
    tree_word_t            new_word;

    assign edge_stall = (state_reg != S_IDLE);
    assign in_take    = edge_valid && !edge_stall;
    assign edge_ok    = ({1'b0, edge_word.edge_from} < node_count_reg)
                     && ({1'b0, edge_word.edge_to} < node_count_reg)
                     && (edge_count_reg < COUNT_BITS'(MAX_EDGES));
    assign out_free   = !out_vld_reg || !tree_stall;
    assign tree_valid = out_vld_reg;
    assign tree_word  = out_reg;

    assign rd_issue   = (state_reg == S_SCAN) && (issue_reg < edge_count_reg);
    assign cand_key   = {~rdata_reg.weight[WEIGHT_BITS-1], rdata_reg.weight[WEIGHT_BITS-2:0],
                         ridx_reg};
    assign cand_better = rv_reg && (!prev_vld_reg || cand_key > prev_key_reg)
                      && (!best_vld_reg || cand_key < best_key_reg);
    assign parent_of  = pdvld_reg ? pdata_reg : cur_reg;
    assign link_en    = (state_reg == S_FB_CHK) && (parent_of == cur_reg)
                     && (root_a_reg != cur_reg);

    always_comb
    begin
        new_word              = '0;
        new_word.tree_from    = best_reg.from;
        new_word.tree_to      = best_reg.to;
        new_word.tree_weight  = best_reg.weight;
        new_word.dropped_flag = run_drop_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take && edge_word.final_edge)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!rd_issue && !rv_reg)
                    state_next = best_vld_reg ? S_FA_RD : S_FINISH;
            end
            S_FA_RD:  state_next = S_FA_CHK;
            S_FA_CHK: state_next = (parent_of == cur_reg) ? S_FB_RD : S_FA_RD;
            S_FB_RD:  state_next = S_FB_CHK;
            S_FB_CHK:
            begin
                if (parent_of != cur_reg)
                    state_next = S_FB_RD;
                else if (link_en && pend_cnt_reg < OUT_CNT_BITS'(OUT_CAP))
                    state_next = S_PUSH;
                else
                    state_next = S_SCAN;
            end
            S_PUSH:
            begin
                if (!pend_vld_reg || out_free)
                    state_next = S_SCAN;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        edge_count_next = edge_count_reg;
        dropped_next    = dropped_reg;
        run_drop_next   = run_drop_reg;
        pvld_next       = pvld_reg;
        issue_next      = issue_reg;
        best_key_next   = best_key_reg;
        best_vld_next   = best_vld_reg;
        best_next       = best_reg;
        prev_key_next   = prev_key_reg;
        prev_vld_next   = prev_vld_reg;
        cur_next        = cur_reg;
        root_a_next     = root_a_reg;
        pend_next       = pend_reg;
        pend_vld_next   = pend_vld_reg;
        pend_cnt_next   = pend_cnt_reg;
        out_next        = out_reg;
        out_vld_next    = out_vld_reg && tree_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (edge_ok)
                        edge_count_next = edge_count_reg + 1'b1;
                    if (edge_word.final_edge)
                    begin
                        run_drop_next = dropped_reg || !edge_ok;
                        issue_next    = '0;
                        best_vld_next = 1'b0;
                        prev_vld_next = 1'b0;
                        pend_vld_next = 1'b0;
                        pend_cnt_next = '0;
                    end
                    else if (!edge_ok)
                        dropped_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (rd_issue)
                    issue_next = issue_reg + 1'b1;
                if (cand_better)
                begin
                    best_key_next = cand_key;
                    best_vld_next = 1'b1;
                    best_next     = rdata_reg;
                end
                if (!rd_issue && !rv_reg && best_vld_reg)
                begin
                    prev_key_next = best_key_reg;
                    prev_vld_next = 1'b1;
                    cur_next      = best_reg.from;
                end
            end
            S_FA_CHK:
            begin
                if (parent_of == cur_reg)
                begin
                    root_a_next = cur_reg;
                    cur_next    = best_reg.to;
                end
                else
                    cur_next = parent_of;
            end
            S_FB_CHK:
            begin
                if (parent_of != cur_reg)
                    cur_next = parent_of;
                else
                begin
                    issue_next    = '0;
                    best_vld_next = 1'b0;
                    if (link_en)
                        pvld_next[root_a_reg] = 1'b1;
                end
            end
            S_PUSH:
            begin
                if (!pend_vld_reg)
                begin
                    pend_next     = new_word;
                    pend_vld_next = 1'b1;
                    pend_cnt_next = pend_cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_next      = pend_reg;
                    out_vld_next  = 1'b1;
                    pend_next     = new_word;
                    pend_cnt_next = pend_cnt_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_next           = pend_reg;
                        out_next.tree_last = 1'b1;
                    end
                    else
                    begin
                        out_next              = '0;
                        out_next.tree_last    = 1'b1;
                        out_next.tree_empty   = 1'b1;
                        out_next.dropped_flag = run_drop_reg;
                    end
                    out_vld_next    = 1'b1;
                    pend_vld_next   = 1'b0;
                    edge_count_next = '0;
                    dropped_next    = 1'b0;
                    pvld_next       = '0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= CFG_BITS'(MAX_NODES);
            edge_count_reg <= '0;
            dropped_reg    <= 1'b0;
            pvld_reg       <= '0;
            rv_reg         <= 1'b0;
            best_vld_reg   <= 1'b0;
            prev_vld_reg   <= 1'b0;
            pend_vld_reg   <= 1'b0;
            pend_cnt_reg   <= '0;
            out_vld_reg    <= 1'b0;
            issue_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
                node_count_reg <= cfg_wdata;
            edge_count_reg <= edge_count_next;
            dropped_reg    <= dropped_next;
            pvld_reg       <= pvld_next;
            rv_reg         <= rd_issue;
            best_vld_reg   <= best_vld_next;
            prev_vld_reg   <= prev_vld_next;
            pend_vld_reg   <= pend_vld_next;
            pend_cnt_reg   <= pend_cnt_next;
            out_vld_reg    <= out_vld_next;
            issue_reg      <= issue_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        run_drop_reg <= run_drop_next;
        best_key_reg <= best_key_next;
        best_reg     <= best_next;
        prev_key_reg <= prev_key_next;
        cur_reg      <= cur_next;
        root_a_reg   <= root_a_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        ridx_reg     <= issue_reg[EDGE_BITS-1:0];
    end

    // edge memory: write on load, registered read during the scan
    always_ff @(posedge clk)
    begin
        if (in_take && edge_ok)
            edge_mem[edge_count_reg[EDGE_BITS-1:0]] <= '{from: edge_word.edge_from,
                to: edge_word.edge_to, weight: edge_word.edge_weight};
        rdata_reg <= edge_mem[issue_reg[EDGE_BITS-1:0]];
    end

    // parent memory: link the first root under the second
    always_ff @(posedge clk)
    begin
        if (link_en)
            parent_mem[root_a_reg] <= cur_reg;
        pdata_reg <= parent_mem[cur_reg];
        pdvld_reg <= pvld_reg[cur_reg];
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= COUNT_BITS'(MAX_EDGES))
        else $error("edge count beyond store");
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> issue_reg <= edge_count_reg)
        else $error("scan beyond stored edges");
    a_pend_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg <= OUT_CNT_BITS'(OUT_CAP))
        else $error("too many tree edges queued");
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg) == S_FINISH && state_reg == S_IDLE |-> !pend_vld_reg && pvld_reg == '0)
        else $error("graph state not cleared");
    a_link_roots: assert property (@(posedge clk) disable iff (!rst_n)
        link_en |-> !pvld_reg[root_a_reg] && !pvld_reg[cur_reg])
        else $error("link of a non-root");

endmodule
